>>> sv/rect_to_polar_converter_unit_assert.svh
// Assertion macros for the rect_to_polar_converter_unit block.
// Clock and active-low reset are passed in by the user of each macro.
`ifndef RECT_TO_POLAR_CONVERTER_UNIT_ASSERT_SVH
`define RECT_TO_POLAR_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define R2P_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define R2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/r2p_pkg.sv
// r2p_pkg: constants, sideband type and arctangent table for the rect-to-polar block.
// No dependencies.
package r2p_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned ITERATIONS_DEF = 16;

  localparam int unsigned IN_W       = 16;  // input field width
  localparam int unsigned OUT_W      = 16;  // magnitude / angle field width
  localparam int unsigned ZW         = 32;  // angle accumulator, degrees * 2^24
  localparam int unsigned PRESCALE   = 16;  // CORDIC x/y fractional bits
  localparam int unsigned GUARD_BITS = 3;   // sign + CORDIC gain growth
  localparam int unsigned ANG_FRAC   = 16;  // Q.24 -> Q.8

  localparam logic [OUT_W-1:0] ANGLE_LIMIT = 16'd23040;  // 90.0 deg in Q7.8
  localparam logic [OUT_W-1:0] MAG_MAX     = 16'hFFFF;
  localparam logic [ZW-1:0]    ROUND_HALF  = 32'd32768;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic flip;    // x and y of opposite sign
  } r2p_side_t;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_q24(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 32'sd754974720;
      1:       v = 32'sd445687602;
      2:       v = 32'sd235489088;
      3:       v = 32'sd119537938;
      4:       v = 32'sd60000934;
      5:       v = 32'sd30029717;
      6:       v = 32'sd15018523;
      7:       v = 32'sd7509720;
      8:       v = 32'sd3754917;
      9:       v = 32'sd1877466;
      10:      v = 32'sd938734;
      11:      v = 32'sd469367;
      12:      v = 32'sd234684;
      13:      v = 32'sd117342;
      14:      v = 32'sd58671;
      15:      v = 32'sd29335;
      16:      v = 32'sd14668;
      17:      v = 32'sd7334;
      18:      v = 32'sd3667;
      19:      v = 32'sd1833;
      20:      v = 32'sd917;
      21:      v = 32'sd458;
      22:      v = 32'sd229;
      23:      v = 32'sd115;
      24:      v = 32'sd57;
      25:      v = 32'sd29;
      26:      v = 32'sd14;
      27:      v = 32'sd7;
      28:      v = 32'sd4;
      29:      v = 32'sd2;
      30:      v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/r2p_front.sv
// r2p_front: input stage. Folds the vector into the first quadrant, squares and sums.
// Depends on r2p_pkg.
module r2p_front
  import r2p_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned SW = 2 * DATA_WIDTH,
  localparam int unsigned CW = DATA_WIDTH + PRESCALE + GUARD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [IN_W-1:0] x_coord_i,
  input  logic signed [IN_W-1:0] y_coord_i,
  output logic                 valid_o,
  output r2p_side_t            side_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [SW-1:0]        sum_o
);

  logic [DATA_WIDTH-1:0] x_d, y_d, ax, ay;
  logic                  valid_r;
  r2p_side_t             side_r, side_nxt;
  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;

  // when DATA_WIDTH <= IN_W only the low DATA_WIDTH bits count; else the input is zero-extended
  if (DATA_WIDTH <= IN_W) begin : g_narrow
    assign x_d = x_coord_i[DATA_WIDTH-1:0];
    assign y_d = y_coord_i[DATA_WIDTH-1:0];
  end else begin : g_wide
    assign x_d = {{(DATA_WIDTH-IN_W){1'b0}}, x_coord_i};
    assign y_d = {{(DATA_WIDTH-IN_W){1'b0}}, y_coord_i};
  end

  always_comb begin
    ax              = x_d[DATA_WIDTH-1] ? (~x_d + 1'b1) : x_d;
    ay              = y_d[DATA_WIDTH-1] ? (~y_d + 1'b1) : y_d;
    sum_nxt         = ax * ax + ay * ay;
    x_nxt           = $signed({{GUARD_BITS{1'b0}}, ax, {PRESCALE{1'b0}}});
    y_nxt           = $signed({{GUARD_BITS{1'b0}}, ay, {PRESCALE{1'b0}}});
    side_nxt.x_zero = (x_d == '0);
    side_nxt.y_zero = (y_d == '0);
    side_nxt.flip   = x_d[DATA_WIDTH-1] ^ y_d[DATA_WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      side_r <= side_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign sum_o   = sum_r;

endmodule

>>> sv/r2p_cell.sv
// r2p_cell: one pipeline cell, one CORDIC vectoring micro-rotation plus one
// square-root digit, each passed through once STAGE reaches ITERATIONS or DATA_WIDTH. Depends on r2p_pkg.
module r2p_cell
  import r2p_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned ITERATIONS = ITERATIONS_DEF,
  parameter int unsigned STAGE      = 0,
  localparam int unsigned SW = 2 * DATA_WIDTH,
  localparam int unsigned CW = DATA_WIDTH + PRESCALE + GUARD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  r2p_side_t            side_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SW-1:0]        rem_i,
  input  logic [SW-1:0]        root_i,
  output logic                 valid_o,
  output r2p_side_t            side_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [SW-1:0]        rem_o,
  output logic [SW-1:0]        root_o
);

  logic                 valid_r;
  r2p_side_t            side_r;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SW-1:0]        rem_r, rem_nxt, root_r, root_nxt;

  if (STAGE < ITERATIONS) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_K = atan_q24(STAGE);
    // drive y toward zero; y >= 0 rotates clockwise
    always_comb begin
      if (!y_i[CW-1]) begin
        x_nxt = x_i + (y_i >>> STAGE);
        y_nxt = y_i - (x_i >>> STAGE);
        z_nxt = z_i + ATAN_K;
      end else begin
        x_nxt = x_i - (y_i >>> STAGE);
        y_nxt = y_i + (x_i >>> STAGE);
        z_nxt = z_i - ATAN_K;
      end
    end
  end else begin : g_rot_pass
    assign x_nxt = x_i;
    assign y_nxt = y_i;
    assign z_nxt = z_i;
  end

  if (STAGE < DATA_WIDTH) begin : g_sqrt
    localparam int unsigned SHIFT = 2 * (DATA_WIDTH - 1 - STAGE);
    localparam logic [SW:0] BIT_K = (SW + 1)'(1) << SHIFT;
    logic [SW:0] trial;
    always_comb begin
      trial = {1'b0, root_i} + BIT_K;
      if ({1'b0, rem_i} >= trial) begin
        rem_nxt  = rem_i - trial[SW-1:0];
        root_nxt = (root_i >> 1) + BIT_K[SW-1:0];
      end else begin
        rem_nxt  = rem_i;
        root_nxt = root_i >> 1;
      end
    end
  end else begin : g_sqrt_pass
    assign rem_nxt  = rem_i;
    assign root_nxt = root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      side_r <= side_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

endmodule

>>> sv/r2p_back.sv
// r2p_back: output stage. Rounds magnitude and angle, applies the axis cases,
// holds the result register and one skid entry. Depends on r2p_pkg.
module r2p_back
  import r2p_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned SW = 2 * DATA_WIDTH,
  localparam int unsigned MW = DATA_WIDTH + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  r2p_side_t               side_i,
  input  logic signed [ZW-1:0]    z_i,
  input  logic [SW-1:0]           rem_i,
  input  logic [SW-1:0]           root_i,
  output logic                    pipe_ready_o,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_W-1:0]        out_magnitude,
  output logic signed [OUT_W-1:0] out_angle_deg,
  output logic                    out_angle_undefined
);

  typedef struct packed {
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] ang;
    logic             undef;
  } r2p_res_t;

  r2p_res_t            res;
  r2p_res_t            out_r, out_nxt, skid_r, skid_nxt;
  logic                out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                take, arrive, round_up;
  logic [MW-1:0]       mag_round;
  logic [MW+OUT_W-1:0] mag_wide;
  logic [ZW-1:0]       z_pos, z_rnd;
  logic [OUT_W-1:0]    ang_mag, ang_clip;

  always_comb begin
    // remainder above root means the value is past root + 1/2
    round_up  = rem_i > root_i;
    mag_round = {1'b0, root_i[DATA_WIDTH-1:0]} + {{DATA_WIDTH{1'b0}}, round_up};
    mag_wide  = (MW + OUT_W)'(mag_round);
    if (mag_wide > (MW + OUT_W)'(MAG_MAX)) begin
      res.mag = MAG_MAX;
    end else begin
      res.mag = mag_wide[OUT_W-1:0];
    end

    z_pos    = z_i[ZW-1] ? '0 : z_i;
    z_rnd    = z_pos + ROUND_HALF;
    ang_mag  = z_rnd[ANG_FRAC +: OUT_W];
    ang_clip = (ang_mag > ANGLE_LIMIT) ? ANGLE_LIMIT : ang_mag;

    res.undef = 1'b0;
    if (side_i.x_zero && side_i.y_zero) begin
      res.ang   = '0;
      res.undef = 1'b1;
    end else if (side_i.x_zero) begin
      res.ang = side_i.flip ? (~ANGLE_LIMIT + 1'b1) : ANGLE_LIMIT;
    end else if (side_i.y_zero) begin
      res.ang = '0;
    end else begin
      res.ang = side_i.flip ? (~ang_clip + 1'b1) : ang_clip;
    end
  end

  always_comb begin
    take           = out_valid_r && out_ready;
    arrive         = valid_i && !skid_valid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (arrive) begin
      if (!out_valid_r || take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // pipeline advances whenever the skid entry is free
  assign pipe_ready_o        = !skid_valid_r;
  assign out_valid           = out_valid_r;
  assign out_magnitude       = out_r.mag;
  assign out_angle_deg       = $signed(out_r.ang);
  assign out_angle_undefined = out_r.undef;

endmodule

>>> sv/rect_to_polar_converter_unit.sv
// rect_to_polar_converter_unit: (x, y) to rounded magnitude and Q7.8 angle in degrees.
// Pipeline: input stage, one cell per CORDIC micro-rotation / square-root digit,
//   output register.
// Throughput: one request per cycle; the cell chain stalls only when the skid entry is full.
// Reset (rst_n low, synchronous) clears valid bits only; no state carries between requests.
module rect_to_polar_converter_unit
  import r2p_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned ITERATIONS = ITERATIONS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_x_coord,
  input  logic signed [IN_W-1:0]  in_y_coord,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_W-1:0]        out_magnitude,
  output logic signed [OUT_W-1:0] out_angle_deg,
  output logic                    out_angle_undefined
);

`include "rect_to_polar_converter_unit_assert.svh"

  localparam int unsigned NCELL = (DATA_WIDTH > ITERATIONS) ? DATA_WIDTH : ITERATIONS;
  localparam int unsigned SW    = 2 * DATA_WIDTH;
  localparam int unsigned CW    = DATA_WIDTH + PRESCALE + GUARD_BITS;

  logic                 pipe_ready;
  logic                 v_w    [NCELL+1];
  r2p_side_t            side_w [NCELL+1];
  logic signed [CW-1:0] x_w    [NCELL+1];
  logic signed [CW-1:0] y_w    [NCELL+1];
  logic signed [ZW-1:0] z_w    [NCELL+1];
  logic [SW-1:0]        rem_w  [NCELL+1];
  logic [SW-1:0]        root_w [NCELL+1];

  assign in_ready = pipe_ready;

  r2p_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (pipe_ready),
    .valid_i  (in_valid),
    .x_coord_i(in_x_coord),
    .y_coord_i(in_y_coord),
    .valid_o  (v_w[0]),
    .side_o   (side_w[0]),
    .x_o      (x_w[0]),
    .y_o      (y_w[0]),
    .sum_o    (rem_w[0])
  );

  assign z_w[0]    = '0;
  assign root_w[0] = '0;

  for (genvar s = 0; s < NCELL; s++) begin : g_cell
    r2p_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .ITERATIONS(ITERATIONS),
      .STAGE     (s)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en_i   (pipe_ready),
      .valid_i(v_w[s]),
      .side_i (side_w[s]),
      .x_i    (x_w[s]),
      .y_i    (y_w[s]),
      .z_i    (z_w[s]),
      .rem_i  (rem_w[s]),
      .root_i (root_w[s]),
      .valid_o(v_w[s+1]),
      .side_o (side_w[s+1]),
      .x_o    (x_w[s+1]),
      .y_o    (y_w[s+1]),
      .z_o    (z_w[s+1]),
      .rem_o  (rem_w[s+1]),
      .root_o (root_w[s+1])
    );
  end

  r2p_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .valid_i            (v_w[NCELL]),
    .side_i             (side_w[NCELL]),
    .z_i                (z_w[NCELL]),
    .rem_i              (rem_w[NCELL]),
    .root_i             (root_w[NCELL]),
    .pipe_ready_o       (pipe_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_magnitude      (out_magnitude),
    .out_angle_deg      (out_angle_deg),
    .out_angle_undefined(out_angle_undefined)
  );

  `R2P_ASSERT_IMPL(a_undef_is_zero, clk, rst_n, out_valid && out_angle_undefined, out_magnitude == '0 && out_angle_deg == '0, "zero vector must give zero magnitude and angle")
  `R2P_ASSERT_IMPL(a_angle_range, clk, rst_n, out_valid, out_angle_deg <= $signed(ANGLE_LIMIT) && out_angle_deg >= -$signed(ANGLE_LIMIT), "angle outside +-90 degrees")
  `R2P_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, !pipe_ready, out_valid, "skid entry full while output register empty")
  `R2P_ASSERT_NEXT(a_front_advances, clk, rst_n, v_w[0] && pipe_ready, v_w[1], "request lost between input stage and first cell")

endmodule
